// File: design/assert_macros.svh
// Assertion helpers used by programmable_sound_generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define PSG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define PSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and envelope shape table for the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int CHANNELS  = 3;
  localparam int REG_COUNT = 16;

  localparam int DIVIDEND_W = 21;
  localparam int DIVISOR_W  = 20;
  localparam int ITER_W     = $clog2(DIVIDEND_W);

  localparam int UNIT_W = 3;
  localparam logic [UNIT_W-1:0] UNIT_ENV   = UNIT_W'(CHANNELS);
  localparam logic [UNIT_W-1:0] UNIT_NOISE = UNIT_W'(CHANNELS + 1);

  // register map
  localparam logic [3:0] REG_NOISE  = 4'd6;
  localparam logic [3:0] REG_MIXER  = 4'd7;
  localparam logic [3:0] REG_AMP    = 4'd8;
  localparam logic [3:0] REG_ENV_LO = 4'd11;
  localparam logic [3:0] REG_ENV_HI = 4'd12;
  localparam logic [3:0] REG_SHAPE  = 4'd13;
  localparam logic [3:0] REG_IO_A   = 4'd14;

  localparam logic [7:0] MIXER_RESET = 8'h3f;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BLK_ZERO = 2'd0,
    BLK_RISE = 2'd1,
    BLK_FALL = 2'd2,
    BLK_FULL = 2'd3
  } blk_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quo;
    logic [DIVISOR_W-1:0]  rem;
  } div_rsp_t;

  // block used by each shape in phases 0..2
  function automatic blk_t shape_block(input logic [3:0] shape, input logic [1:0] phase);
    blk_t b;
    b = BLK_ZERO;
    if (phase == 2'd0) begin
      b = shape[2] ? BLK_RISE : BLK_FALL;
    end else if (shape[3]) begin
      case (shape[2:0])
        3'd0: b = BLK_FALL;
        3'd2: b = (phase == 2'd1) ? BLK_RISE : BLK_FALL;
        3'd3: b = BLK_FULL;
        3'd4: b = BLK_RISE;
        3'd5: b = BLK_FULL;
        3'd6: b = (phase == 2'd1) ? BLK_FALL : BLK_RISE;
        default: b = BLK_ZERO;
      endcase
    end
    return b;
  endfunction

  function automatic logic [3:0] block_value(input blk_t b, input logic [3:0] step);
    logic [3:0] v;
    case (b)
      BLK_ZERO: v = 4'd0;
      BLK_RISE: v = step;
      BLK_FALL: v = 4'd15 - step;
      default:  v = 4'd15;
    endcase
    return v;
  endfunction

endpackage

// File: design/psg_div.sv
// ----------------------------------------------------------------------------
// psg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  psg_pkg::div_req_t req,
  output psg_pkg::div_rsp_t rsp
);
  import psg_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [ITER_W-1:0]     iter_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (iter_r == ITER_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIVISOR_W'(trial - {1'b0, dsr_r}) : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: design/programmable_sound_generator.sv
// ----------------------------------------------------------------------------
// programmable_sound_generator
// Three-channel tone/noise/envelope sound generator with a 16 x 8 register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): each request carries an opcode
//   (select, write, read, sample), a value byte and a noise bit.
//   Result channel (out_valid/out_stall): exactly one result per request.
//   Config port (APB style): clocks_per_sample, read at byte address 0; a write to any address sets it.
// Timing:
//   Select, write and read finish in the accept cycle; the result is
//   registered and shown on the next cycle.
//   A sample request runs five divisions (three tones, envelope, noise) on
//   one shared restoring divider of 21 bits, each through load, the bit
//   iterations and claim; then the sum is registered. One request is in
//   flight; the next is taken no earlier than the edge that takes the result.
// Reset: register file clears (mixer reads 0x3f), counters and levels clear,
//   clocks_per_sample returns to 79.
// Stall: a result held by out_stall blocks the next request until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module programmable_sound_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_value,
  input  logic        in_noise_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [5:0]  out_sample,
  output logic        out_io_write_valid,
  output logic [7:0]  out_io_write_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import psg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t            st_r;
  logic [15:0]       cps_r;
  logic [7:0]        regs_r [REG_COUNT];
  logic [3:0]        sel_r;
  logic [15:0]       tone_cnt_r [CHANNELS];
  logic [CHANNELS-1:0] tone_lvl_r;
  logic [19:0]       env_cnt_r;
  logic [3:0]        env_step_r;
  logic [1:0]        env_phase_r;
  logic [3:0]        env_lvl_r;
  logic [8:0]        noise_cnt_r;
  logic              noise_lvl_r;
  logic              nbit_r;
  logic [UNIT_W-1:0] unit_r;

  logic              out_valid_r;
  logic [7:0]        rd_r;
  logic [5:0]        smp_r;
  logic              iov_r;
  logic [7:0]        iod_r;

  logic              out_free;
  logic              in_acc;
  logic              res_load;
  op_t               op;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [DIVISOR_W-1:0] tone_div [CHANNELS];
  logic [DIVISOR_W-1:0] env_div;
  logic [DIVISOR_W-1:0] noise_div;
  logic [DIVIDEND_W-1:0] cur_cnt;
  logic [DIVISOR_W-1:0]  cur_div;

  logic [21:0]       step_full;
  logic [18:0]       phase_full;
  logic [1:0]        phase_fold;
  logic [5:0]        sum;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((st_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign op       = op_t'(in_opcode);
  // a new result lands in the output register this cycle
  assign res_load = (in_acc && (op != OP_SAMPLE)) || ((st_r == ST_FIN) && out_free);

  // divisors: period (zero counts as one) times 16
  always_comb begin
    logic [11:0] tp;
    logic [15:0] ep;
    logic [4:0]  np;
    for (int c = 0; c < CHANNELS; c++) begin
      tp = {regs_r[2*c+1][3:0], regs_r[2*c]};
      if (tp == '0) tp = 12'd1;
      tone_div[c] = DIVISOR_W'({tp, 4'd0});
    end
    ep = {regs_r[REG_ENV_HI], regs_r[REG_ENV_LO]};
    if (ep == '0) ep = 16'd1;
    env_div = {ep, 4'd0};
    np = regs_r[REG_NOISE][4:0];
    if (np == '0) np = 5'd1;
    noise_div = DIVISOR_W'({np, 4'd0});
  end

  always_comb begin
    cur_cnt = '0;
    cur_div = noise_div;
    if (unit_r == UNIT_ENV) begin
      cur_cnt = DIVIDEND_W'(env_cnt_r) + DIVIDEND_W'(cps_r);
      cur_div = env_div;
    end else if (unit_r == UNIT_NOISE) begin
      cur_cnt = DIVIDEND_W'(noise_cnt_r) + DIVIDEND_W'(cps_r);
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (unit_r == UNIT_W'(c)) begin
          cur_cnt = DIVIDEND_W'(tone_cnt_r[c]) + DIVIDEND_W'(cps_r);
          cur_div = tone_div[c];
        end
      end
    end
  end

  assign dreq.start    = (st_r == ST_LOAD);
  assign dreq.dividend = cur_cnt;
  assign dreq.divisor  = cur_div;

  psg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // envelope advance at full width, then fold past the first cycle
  always_comb begin
    step_full  = 22'(env_step_r) + 22'(drsp.quo);
    phase_full = 19'(env_phase_r) + 19'(step_full[21:4]);
    if (phase_full > 19'd2) phase_fold = phase_full[0] ? 2'd1 : 2'd2;
    else                    phase_fold = phase_full[1:0];
  end

  always_comb begin
    logic [3:0] vol;
    logic       on;
    sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      on  = (tone_lvl_r[c] || regs_r[REG_MIXER][c]) &&
            (noise_lvl_r || regs_r[REG_MIXER][c+3]);
      vol = regs_r[REG_AMP + 4'(c)][4] ? env_lvl_r : regs_r[REG_AMP + 4'(c)][3:0];
      if (on) sum = sum + 6'(vol);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cps_r       <= 16'd79;
      sel_r       <= '0;
      tone_lvl_r  <= '0;
      env_cnt_r   <= '0;
      env_step_r  <= '0;
      env_phase_r <= '0;
      env_lvl_r   <= '0;
      noise_cnt_r <= '0;
      noise_lvl_r <= 1'b0;
      unit_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= (4'(i) == REG_MIXER) ? MIXER_RESET : 8'd0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        tone_cnt_r[c] <= '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) cps_r <= cfg_pwdata[15:0];
      if (out_valid_r && !out_stall && !res_load) out_valid_r <= 1'b0;

      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            smp_r <= '0;
            case (op)
              OP_SELECT: begin
                sel_r       <= in_value[3:0];
                rd_r        <= '0;
                iov_r       <= 1'b0;
                iod_r       <= '0;
                out_valid_r <= 1'b1;
              end
              OP_WRITE: begin
                regs_r[sel_r] <= in_value;
                if (sel_r == REG_SHAPE) begin
                  env_cnt_r   <= '0;
                  env_step_r  <= '0;
                  env_phase_r <= '0;
                end
                rd_r        <= '0;
                iov_r       <= (sel_r == REG_IO_A);
                iod_r       <= (sel_r == REG_IO_A) ? in_value : 8'd0;
                out_valid_r <= 1'b1;
              end
              OP_READ: begin
                rd_r        <= regs_r[sel_r];
                iov_r       <= 1'b0;
                iod_r       <= '0;
                out_valid_r <= 1'b1;
              end
              default: begin
                rd_r   <= '0;
                iov_r  <= 1'b0;
                iod_r  <= '0;
                nbit_r <= in_noise_bit;
                unit_r <= '0;
                st_r   <= ST_LOAD;
              end
            endcase
          end
        end
        ST_LOAD: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (drsp.done) begin
            if (unit_r == UNIT_ENV) begin
              env_cnt_r <= drsp.rem;
              if (drsp.quo != '0) begin
                env_step_r  <= step_full[3:0];
                env_phase_r <= phase_fold;
                env_lvl_r   <= block_value(shape_block(regs_r[REG_SHAPE][3:0], phase_fold),
                                           step_full[3:0]);
              end
            end else if (unit_r == UNIT_NOISE) begin
              noise_cnt_r <= drsp.rem[8:0];
              if (drsp.quo != '0) noise_lvl_r <= nbit_r;
            end else begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (unit_r == UNIT_W'(c)) begin
                  tone_cnt_r[c] <= drsp.rem[15:0];
                  tone_lvl_r[c] <= tone_lvl_r[c] ^ drsp.quo[0];
                end
              end
            end
            if (unit_r == UNIT_NOISE) st_r <= ST_FIN;
            else begin
              unit_r <= unit_r + 1'b1;
              st_r   <= ST_LOAD;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            smp_r       <= sum;
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = rd_r;
  assign out_sample         = smp_r;
  assign out_io_write_valid = iov_r;
  assign out_io_write_data  = iod_r;
  assign cfg_prdata         = (cfg_paddr == 2'd0) ? {16'd0, cps_r} : 32'd0;
  assign cfg_pready         = 1'b1;

  `PSG_ASSERT(a_busy_stalls, clk, rst_n, (st_r != ST_IDLE) |-> in_stall, "request taken while busy")
  `PSG_ASSERT(a_sample_range, clk, rst_n, out_valid |-> (out_sample <= 6'd45), "sample above 45")
  `PSG_ASSERT(a_div_done_wait, clk, rst_n, drsp.done |-> (st_r == ST_WAIT), "divider result unclaimed")

endmodule

// File: verif/programmable_sound_generator_tb.sv
// ----------------------------------------------------------------------------
// programmable_sound_generator_tb
// Self-checking bench: directed table then random register and sample
// requests, checked against a behavioural model of the sound generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module programmable_sound_generator_tb;
  import psg_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = 2'd0;
  logic [7:0]  in_value = 8'd0;
  logic        in_noise_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic [5:0]  out_sample;
  logic        out_io_write_valid;
  logic [7:0]  out_io_write_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  programmable_sound_generator u_dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [7:0] rd;
    logic [5:0] smp;
    logic       iov;
    logic [7:0] iod;
  } psg_res_t;

  // model state
  logic [15:0] m_cps;
  logic [7:0]  m_regs [16];
  logic [3:0]  m_sel;
  int unsigned m_tone_cnt [3];
  logic        m_tone_lvl [3];
  int unsigned m_env_cnt, m_env_step, m_env_phase;
  logic [3:0]  m_env_lvl;
  int unsigned m_noise_cnt;
  logic        m_noise_lvl;

  psg_res_t    expected_q [$];
  int          mismatches = 0;
  int          samples_seen = 0;
  int          results_seen = 0;
  int          sender_idle = 0;
  int          receiver_idle = 0;

  function automatic logic [1:0] env_block(logic [3:0] shape, int unsigned ph);
    logic [1:0] b;
    b = BLK_ZERO;
    if (ph == 0) b = shape[2] ? BLK_RISE : BLK_FALL;
    else if (shape[3]) begin
      case (shape[2:0])
        3'd0: b = BLK_FALL;
        3'd2: b = (ph == 1) ? BLK_RISE : BLK_FALL;
        3'd3: b = BLK_FULL;
        3'd4: b = BLK_RISE;
        3'd5: b = BLK_FULL;
        3'd6: b = (ph == 1) ? BLK_FALL : BLK_RISE;
        default: b = BLK_ZERO;
      endcase
    end
    return b;
  endfunction

  task automatic model_reset();
    m_cps = 16'd79;
    foreach (m_regs[i]) m_regs[i] = 8'd0;
    m_regs[REG_MIXER] = MIXER_RESET;
    m_sel = 4'd0;
    for (int i = 0; i < 3; i++) begin
      m_tone_cnt[i] = 0;
      m_tone_lvl[i] = 1'b0;
    end
    m_env_cnt = 0; m_env_step = 0; m_env_phase = 0; m_env_lvl = 4'd0;
    m_noise_cnt = 0; m_noise_lvl = 1'b0;
  endtask

  function automatic logic [5:0] mix_sample(logic nb);
    int unsigned per, cnt, st, ph, sum;
    logic [1:0] b;
    logic [3:0] vol;
    for (int i = 0; i < 3; i++) begin
      per = {m_regs[2*i+1][3:0], m_regs[2*i]};
      if (per == 0) per = 1;
      per = per << 4;
      cnt = m_tone_cnt[i] + m_cps;
      if (cnt >= per) begin
        m_tone_lvl[i] ^= (cnt / per) & 1;
        m_tone_cnt[i] = cnt % per;
      end else m_tone_cnt[i] = cnt;
    end
    per = {m_regs[REG_ENV_HI], m_regs[REG_ENV_LO]};
    if (per == 0) per = 1;
    per = per << 4;
    cnt = m_env_cnt + m_cps;
    if (cnt >= per) begin
      st = m_env_step + cnt / per;
      ph = m_env_phase + (st >> 4);
      m_env_cnt = cnt % per;
      m_env_step = st & 15;
      if (ph > 2) ph = ph[0] ? 1 : 2;
      m_env_phase = ph;
      b = env_block(m_regs[REG_SHAPE][3:0], ph);
      case (b)
        BLK_ZERO: m_env_lvl = 4'd0;
        BLK_RISE: m_env_lvl = m_env_step[3:0];
        BLK_FALL: m_env_lvl = 4'd15 - m_env_step[3:0];
        default:  m_env_lvl = 4'd15;
      endcase
    end else m_env_cnt = cnt;
    per = m_regs[REG_NOISE][4:0];
    if (per == 0) per = 1;
    per = per << 4;
    cnt = m_noise_cnt + m_cps;
    if (cnt >= per) begin
      m_noise_lvl = nb;
      m_noise_cnt = cnt % per;
    end else m_noise_cnt = cnt;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      vol = m_regs[REG_AMP+i][4] ? m_env_lvl : m_regs[REG_AMP+i][3:0];
      if ((m_tone_lvl[i] || m_regs[REG_MIXER][i]) &&
          (m_noise_lvl || m_regs[REG_MIXER][i+3]))
        sum += vol;
    end
    return sum[5:0];
  endfunction

  function automatic psg_res_t predict_request(op_t op, logic [7:0] v, logic nb);
    psg_res_t r;
    r = '0;
    case (op)
      OP_SELECT: m_sel = v[3:0];
      OP_WRITE: begin
        if (m_sel == REG_SHAPE) begin
          m_env_cnt = 0; m_env_step = 0; m_env_phase = 0;
        end
        if (m_sel == REG_IO_A) begin
          r.iov = 1'b1;
          r.iod = v;
        end
        m_regs[m_sel] = v;
      end
      OP_READ: r.rd = m_regs[m_sel];
      default: r.smp = mix_sample(nb);
    endcase
    return r;
  endfunction

  // idling percentages, set per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_stall) receiver_idle++;
    end
  end

  always @(posedge clk) begin
    psg_res_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_read_data, out_sample, out_io_write_valid, out_io_write_data};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.smp != 0) samples_seen++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // a request is queued when it is accepted; check_typed enables a check against typed, a hand-read result
  // valid stays up after the request so back-to-back requests have no gap
  task automatic send_request(op_t op, logic [7:0] v, logic nb,
                              bit check_typed = 0, psg_res_t typed = '0);
    psg_res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      sender_idle++;
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= v;
    in_noise_bit <= nb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_request(op, v, nb);
    if (check_typed && p !== typed) begin
      mismatches++;
      if (mismatches <= 10) $display("model disagrees with table: %p vs %p", typed, p);
    end
    expected_q.push_back(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic cfg_write(logic [15:0] cps);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 2'd0;
    cfg_pwdata <= {16'd0, cps};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    m_cps = cps;
  endtask

  typedef struct {
    op_t        op;
    logic [7:0] v;
    logic       nb;
    bit         typed;
    psg_res_t   r;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{OP_READ,   8'h00, 1'b0, 1, '{8'h00, 6'd0, 1'b0, 8'h00}},
    '{OP_SELECT, 8'hf7, 1'b1, 1, '0},
    '{OP_READ,   8'h00, 1'b0, 1, '{8'h3f, 6'd0, 1'b0, 8'h00}},
    '{OP_SAMPLE, 8'hff, 1'b1, 1, '0},
    '{OP_SELECT, 8'h0e, 1'b0, 1, '0},
    '{OP_WRITE,  8'hff, 1'b0, 1, '{8'h00, 6'd0, 1'b1, 8'hff}},
    '{OP_WRITE,  8'h00, 1'b1, 1, '{8'h00, 6'd0, 1'b1, 8'h00}},
    '{OP_SELECT, 8'h08, 1'b0, 0, '0},
    '{OP_WRITE,  8'h0f, 1'b0, 0, '0},
    '{OP_SELECT, 8'h09, 1'b0, 0, '0},
    '{OP_WRITE,  8'h1f, 1'b0, 0, '0},
    '{OP_SELECT, 8'h0a, 1'b0, 0, '0},
    '{OP_WRITE,  8'hff, 1'b0, 0, '0},
    '{OP_READ,   8'h00, 1'b0, 1, '{8'hff, 6'd0, 1'b0, 8'h00}},
    '{OP_SELECT, 8'h07, 1'b0, 0, '0},
    '{OP_WRITE,  8'h00, 1'b0, 0, '0},
    '{OP_SAMPLE, 8'h00, 1'b1, 0, '0},
    '{OP_SELECT, 8'h0d, 1'b0, 0, '0},
    '{OP_WRITE,  8'h0e, 1'b0, 0, '0},
    '{OP_SAMPLE, 8'h00, 1'b0, 0, '0},
    '{OP_SELECT, 8'h0b, 1'b0, 0, '0},
    '{OP_WRITE,  8'h01, 1'b0, 0, '0},
    '{OP_SAMPLE, 8'h00, 1'b1, 0, '0},
    '{OP_SAMPLE, 8'h00, 1'b0, 0, '0}
  };

  task automatic random_burst(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        // select then write, with small periods favoured
        send_request(OP_SELECT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_request(OP_WRITE, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                               : 8'($urandom_range(31)), 1'($urandom_range(1)));
      end else if (pick == 4)
        send_request(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        send_request(OP_SAMPLE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [15:0] cps_set [6];
    cps_set = '{16'd1, 16'd65535, 16'd0, 16'd79, 16'd200, 16'd7};
    model_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i])
      send_request(directed[i].op, directed[i].v, directed[i].nb,
                   directed[i].typed, directed[i].r);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(ph == 5 ? 16'($urandom_range(1, 65535)) : cps_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      random_burst(200);
      send_idle_pct = 0;
      drain();
    end
    recv_stall_pct = 0;
    drain();
    $display("ran %0d results, %0d non-zero samples, six clock-rate settings",
             results_seen, samples_seen);
    $display("sender idled %0d cycles, receiver stalled %0d cycles",
             sender_idle, receiver_idle);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
